// ===== src/spt_pkg.sv =====
// Package with the parser state, record types, kind codes and size tables.
package spt_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int SPECTRA_CHANNELS = 4;
    localparam int OFS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CH_W = $clog2(SPECTRA_CHANNELS + 1);
    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

    typedef enum logic [3:0] {
        PH_LEN    = 4'd0,
        PH_SKIP   = 4'd1,
        PH_FIBER  = 4'd2,
        PH_FLEN   = 4'd3,
        PH_FID    = 4'd4,
        PH_SCALAR = 4'd5,
        PH_COUNT  = 4'd6,
        PH_SHW    = 4'd7,
        PH_SHH    = 4'd8,
        PH_ELEM   = 4'd9,
        PH_BLEN   = 4'd10,
        PH_BCHAN  = 4'd11,
        PH_SLEN   = 4'd12,
        PH_SID    = 4'd13
    } phase_t;

    localparam logic [4:0] K_FIBER     = 5'd0;
    localparam logic [4:0] K_ERROR     = 5'd1;
    localparam logic [4:0] K_SHAPE_DIM = 5'd6;
    localparam logic [4:0] K_SHAPE     = 5'd7;
    localparam logic [4:0] K_TEMP      = 5'd8;
    localparam logic [4:0] K_SPEC_LO   = 5'd9;
    localparam logic [4:0] K_SPEC_HI   = 5'd16;
    localparam logic [4:0] K_END       = 5'd17;
    localparam logic [4:0] K_ERR_ID    = 5'd18;
    localparam logic [4:0] K_ERR_SIZE  = 5'd19;
    localparam logic [4:0] K_ERR_TRUNC = 5'd20;
    localparam logic [4:0] K_ERR_SUBID = 5'd21;

    localparam logic [15:0] ID_LAST_SCALAR = 16'd2;
    localparam logic [15:0] ID_CURV        = 16'd3;
    localparam logic [15:0] ID_ANGLE       = 16'd4;
    localparam logic [15:0] ID_SHAPE       = 16'd5;
    localparam logic [15:0] ID_TEMP        = 16'd6;
    localparam logic [15:0] ID_SPECTRA     = 16'd7;
    localparam logic [15:0] SUBID_LAST     = 16'd7;

    typedef struct packed {
        phase_t              phase;
        logic [OFS_W-1:0]    ofs;
        logic [31:0]         pkt_len;
        logic [63:0]         shift;
        logic [3:0]          biw;
        logic [4:0]          kind;
        logic [31:0]         elems;
        logic [14:0]         pos;
        logic [31:0]         shw;
        logic [CH_W-1:0]     chan;
        logic [32:0]         blk_end;
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [4:0]  kind;
        logic [1:0]  chan;
        logic [14:0] idx;
        logic [63:0] val;
        logic        pend;
    } rec_t;

    function automatic logic [3:0] kind_size(input logic [4:0] k);
        logic [3:0] n;
        unique case (k)
            5'd1, 5'd11, 5'd13, 5'd15:                 n = 4'd2;
            5'd2, 5'd3, 5'd6, 5'd9, 5'd10:             n = 4'd8;
            5'd4, 5'd5, 5'd7, 5'd8, 5'd12, 5'd14, 5'd16: n = 4'd4;
            default:                                   n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic kind_array(input logic [4:0] k);
        return (k == 5'd4) || (k == 5'd5) || (k == 5'd8) || (k == 5'd12) ||
               (k == 5'd13) || (k == 5'd14) || (k == 5'd15);
    endfunction

endpackage

// ===== src/sensor_packet_tlv_parser.sv =====
// Top level of the sensor packet parser: handshake, state and result registers.
// A record is registered and appears on the output in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle while in_stall is low; the per-byte step logic and one result register set it.
// The input stalls only while a finished record waits and the output is stalled.
// Reset clears the parse state and the output valid, and sets the length limit to 65536.
module sensor_packet_tlv_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        cfg_wr_en,
    input  logic [spt_pkg::CFG_W-1:0]   cfg_wr_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [4:0]                  record_kind,
    output logic [1:0]                  channel,
    output logic [14:0]                 element_index,
    output logic [63:0]                 value,
    output logic                        packet_end
);

    spt_pkg::state_t             state_reg;
    spt_pkg::state_t             state_next;
    spt_pkg::rec_t               rec_next;
    spt_pkg::rec_t               out_reg;
    logic                        out_valid_reg;
    logic [spt_pkg::CFG_W-1:0]   max_len_reg;
    logic                        accept;

    spt_step u_step (
        .cur       (state_reg),
        .data_byte (data_byte),
        .max_len   (max_len_reg),
        .nxt       (state_next),
        .rec       (rec_next)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= spt_pkg::CFG_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= rec_next.valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && rec_next.valid)
            out_reg <= rec_next;
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = out_reg.kind;
    assign channel       = out_reg.chan;
    assign element_index = out_reg.idx;
    assign value         = out_reg.val;
    assign packet_end    = out_reg.pend;

endmodule

// ===== src/spt_step.sv =====
// Per-byte next-state and record logic of the packet parser.
module spt_step (
    input  spt_pkg::state_t                cur,
    input  logic [7:0]                     data_byte,
    input  logic [spt_pkg::CFG_W-1:0]      max_len,
    output spt_pkg::state_t                nxt,
    output spt_pkg::rec_t                  rec
);

    logic [63:0]              word;
    logic [3:0]               cnt1;
    logic [3:0]               take_n;
    logic                     done;
    logic [spt_pkg::OFS_W-1:0] consumed;
    logic [15:0]              id;
    logic [31:0]              lim;
    logic                     abort_pkt;
    logic                     payload;
    spt_pkg::phase_t          bn_phase;
    logic [spt_pkg::CH_W-1:0] bn_chan;
    logic [spt_pkg::CH_W-1:0] chan_inc;
    logic [31:0]              product;

    function automatic spt_pkg::rec_t mk_rec(input logic [4:0] k, input logic [14:0] i,
                                             input logic [63:0] v, input logic [1:0] c);
        spt_pkg::rec_t r;
        r.valid = 1'b1;
        r.kind  = k;
        r.chan  = ((k >= spt_pkg::K_SPEC_LO && k <= spt_pkg::K_SPEC_HI) ||
                   k == spt_pkg::K_ERR_SUBID) ? c : 2'd0;
        r.idx   = i;
        r.val   = v;
        r.pend  = 1'b0;
        return r;
    endfunction

    assign word     = cur.shift | (64'(data_byte) << {cur.biw[2:0], 3'b000});
    assign cnt1     = cur.biw + 4'd1;
    assign consumed = cur.ofs + 1'b1;
    assign id       = word[15:0];
    assign lim      = (32'(max_len) < 32'(spt_pkg::MAX_PACKET_BYTES)) ?
                      32'(max_len) : 32'(spt_pkg::MAX_PACKET_BYTES);
    assign chan_inc = cur.chan + 1'b1;
    assign product  = cur.shw * word[31:0];

    always_comb
    begin
        unique case (cur.phase)
            spt_pkg::PH_FIBER, spt_pkg::PH_BCHAN:        take_n = 4'd1;
            spt_pkg::PH_FID, spt_pkg::PH_SID:            take_n = 4'd2;
            spt_pkg::PH_SCALAR, spt_pkg::PH_ELEM:        take_n = spt_pkg::kind_size(cur.kind);
            default:                                     take_n = 4'd4;
        endcase
    end

    assign done = (cnt1 >= take_n);

    always_comb
    begin
        if (33'(consumed) < cur.blk_end)
        begin
            bn_phase = spt_pkg::PH_SLEN;
            bn_chan  = cur.chan;
        end
        else if (32'(chan_inc) >= 32'(spt_pkg::SPECTRA_CHANNELS))
        begin
            bn_phase = spt_pkg::PH_FLEN;
            bn_chan  = '0;
        end
        else
        begin
            bn_phase = spt_pkg::PH_BLEN;
            bn_chan  = chan_inc;
        end
    end

    always_comb
    begin
        nxt       = cur;
        rec       = '0;
        abort_pkt = 1'b0;
        payload   = (cur.phase != spt_pkg::PH_LEN) && (cur.phase != spt_pkg::PH_SKIP);
        if (cur.phase != spt_pkg::PH_SKIP)
        begin
            nxt.shift = done ? 64'd0 : word;
            nxt.biw   = done ? 4'd0 : cnt1;
        end
        if (payload)
        begin
            nxt.ofs = consumed;
        end
        unique case (cur.phase)
            spt_pkg::PH_LEN:
            begin
                if (done)
                begin
                    nxt.chan = '0;
                    if (word[31:0] > lim)
                    begin
                        rec         = mk_rec(spt_pkg::K_ERR_SIZE, 15'd0, {32'd0, word[31:0]}, 2'd0);
                        rec.pend    = 1'b1;
                        nxt.pkt_len = word[31:0];
                        nxt.phase   = spt_pkg::PH_SKIP;
                    end
                    else if (word[31:0] == 32'd0)
                    begin
                        rec      = mk_rec(spt_pkg::K_ERR_TRUNC, 15'd0, 64'd0, 2'd0);
                        rec.pend = 1'b1;
                    end
                    else
                    begin
                        nxt.pkt_len = word[31:0];
                        nxt.ofs     = '0;
                        nxt.phase   = spt_pkg::PH_FIBER;
                    end
                end
            end
            spt_pkg::PH_SKIP:
            begin
                if (cur.pkt_len <= 32'd1)
                begin
                    nxt.pkt_len = 32'd0;
                    nxt.phase   = spt_pkg::PH_LEN;
                end
                else
                begin
                    nxt.pkt_len = cur.pkt_len - 32'd1;
                end
            end
            spt_pkg::PH_FIBER:
            begin
                rec       = mk_rec(spt_pkg::K_FIBER, 15'd0, {56'd0, word[7:0]}, 2'd0);
                nxt.phase = spt_pkg::PH_FLEN;
            end
            spt_pkg::PH_FLEN:
            begin
                if (done)
                    nxt.phase = spt_pkg::PH_FID;
            end
            spt_pkg::PH_FID:
            begin
                if (done)
                begin
                    if (id <= spt_pkg::ID_LAST_SCALAR)
                    begin
                        nxt.kind  = 5'(id) + 5'd1;
                        nxt.phase = spt_pkg::PH_SCALAR;
                    end
                    else if (id == spt_pkg::ID_CURV || id == spt_pkg::ID_ANGLE)
                    begin
                        nxt.kind  = 5'(id) + 5'd1;
                        nxt.phase = spt_pkg::PH_COUNT;
                    end
                    else if (id == spt_pkg::ID_SHAPE)
                    begin
                        nxt.kind  = spt_pkg::K_SHAPE_DIM;
                        nxt.phase = spt_pkg::PH_SHW;
                    end
                    else if (id == spt_pkg::ID_TEMP)
                    begin
                        nxt.kind  = spt_pkg::K_TEMP;
                        nxt.phase = spt_pkg::PH_COUNT;
                    end
                    else if (id == spt_pkg::ID_SPECTRA)
                    begin
                        nxt.kind  = spt_pkg::K_FIBER;
                        nxt.chan  = '0;
                        nxt.phase = spt_pkg::PH_BLEN;
                    end
                    else
                    begin
                        rec       = mk_rec(spt_pkg::K_ERR_ID, 15'd0, {48'd0, id}, 2'd0);
                        abort_pkt = 1'b1;
                    end
                end
            end
            spt_pkg::PH_SCALAR:
            begin
                if (done)
                begin
                    rec = mk_rec(cur.kind, 15'd0, word, cur.chan[1:0]);
                    if (cur.kind >= spt_pkg::K_SPEC_LO && cur.kind <= spt_pkg::K_SPEC_HI)
                    begin
                        nxt.phase = bn_phase;
                        nxt.chan  = bn_chan;
                    end
                    else
                    begin
                        nxt.phase = spt_pkg::PH_FLEN;
                    end
                end
            end
            spt_pkg::PH_COUNT:
            begin
                if (done)
                begin
                    nxt.elems = word[31:0];
                    nxt.pos   = '0;
                    if (word[31:0] != 32'd0)
                        nxt.phase = spt_pkg::PH_ELEM;
                    else if (cur.kind >= spt_pkg::K_SPEC_LO && cur.kind <= spt_pkg::K_SPEC_HI)
                    begin
                        nxt.phase = bn_phase;
                        nxt.chan  = bn_chan;
                    end
                    else
                        nxt.phase = spt_pkg::PH_FLEN;
                end
            end
            spt_pkg::PH_SHW:
            begin
                if (done)
                begin
                    nxt.shw   = word[31:0];
                    nxt.phase = spt_pkg::PH_SHH;
                end
            end
            spt_pkg::PH_SHH:
            begin
                if (done)
                begin
                    rec       = mk_rec(spt_pkg::K_SHAPE_DIM, 15'd0, {word[31:0], cur.shw}, 2'd0);
                    nxt.kind  = spt_pkg::K_SHAPE;
                    nxt.elems = product;
                    nxt.pos   = '0;
                    nxt.phase = (product == 32'd0) ? spt_pkg::PH_FLEN : spt_pkg::PH_ELEM;
                end
            end
            spt_pkg::PH_ELEM:
            begin
                if (done)
                begin
                    rec       = mk_rec(cur.kind, cur.pos, word, cur.chan[1:0]);
                    nxt.pos   = cur.pos + 15'd1;
                    nxt.elems = (cur.elems != 32'd0) ? cur.elems - 32'd1 : 32'd0;
                    if (cur.elems <= 32'd1)
                    begin
                        if (cur.kind >= spt_pkg::K_SPEC_LO && cur.kind <= spt_pkg::K_SPEC_HI)
                        begin
                            nxt.phase = bn_phase;
                            nxt.chan  = bn_chan;
                        end
                        else
                            nxt.phase = spt_pkg::PH_FLEN;
                    end
                end
            end
            spt_pkg::PH_BLEN:
            begin
                if (done)
                begin
                    nxt.blk_end = 33'(consumed - spt_pkg::OFS_W'(4)) + 33'(word[31:0]);
                    nxt.phase   = spt_pkg::PH_BCHAN;
                end
            end
            spt_pkg::PH_BCHAN:
            begin
                nxt.phase = bn_phase;
                nxt.chan  = bn_chan;
            end
            spt_pkg::PH_SLEN:
            begin
                if (done)
                    nxt.phase = spt_pkg::PH_SID;
            end
            spt_pkg::PH_SID:
            begin
                if (done)
                begin
                    if (id <= spt_pkg::SUBID_LAST)
                    begin
                        nxt.kind  = spt_pkg::K_SPEC_LO + 5'(id);
                        nxt.phase = spt_pkg::kind_array(spt_pkg::K_SPEC_LO + 5'(id)) ?
                                    spt_pkg::PH_COUNT : spt_pkg::PH_SCALAR;
                    end
                    else
                    begin
                        rec       = mk_rec(spt_pkg::K_ERR_SUBID, 15'd0, {48'd0, id},
                                           cur.chan[1:0]);
                        abort_pkt = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt.phase = spt_pkg::PH_LEN;
                nxt.shift = '0;
                nxt.biw   = '0;
            end
        endcase

        if (payload)
        begin
            priority if (abort_pkt)
            begin
                rec.pend    = 1'b1;
                nxt.pkt_len = (cur.pkt_len > 32'(consumed)) ? cur.pkt_len - 32'(consumed) : 32'd0;
                nxt.phase   = (cur.pkt_len > 32'(consumed)) ? spt_pkg::PH_SKIP : spt_pkg::PH_LEN;
                nxt.shift   = '0;
                nxt.biw     = '0;
                nxt.chan    = '0;
            end
            else if (nxt.phase != spt_pkg::PH_LEN && 32'(consumed) >= cur.pkt_len)
            begin
                if (nxt.phase == spt_pkg::PH_FLEN && nxt.biw == 4'd0)
                begin
                    if (!rec.valid)
                        rec = mk_rec(spt_pkg::K_END, 15'd0, 64'd0, 2'd0);
                end
                else
                begin
                    rec = mk_rec(spt_pkg::K_ERR_TRUNC, 15'd0, 64'd0, 2'd0);
                end
                rec.pend  = 1'b1;
                nxt.phase = spt_pkg::PH_LEN;
                nxt.shift = '0;
                nxt.biw   = '0;
                nxt.chan  = '0;
            end
            else
            begin
                nxt.phase = nxt.phase;
            end
        end
    end

endmodule

// ===== src/spt_checker.sv =====
// Port-level checker for the sensor packet parser, bound to the top level.
module spt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  record_kind,
    input logic [1:0]  channel,
    input logic [14:0] element_index,
    input logic [63:0] value,
    input logic        packet_end
);

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(record_kind))
        else $error("stalled request changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_kind <= spt_pkg::K_ERR_SUBID)
        else $error("record kind out of range");

    a_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_kind < spt_pkg::K_SPEC_LO || record_kind > spt_pkg::K_SPEC_HI) &&
        record_kind != spt_pkg::K_ERR_SUBID |-> channel == 2'd0)
        else $error("channel set outside spectra");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind >= spt_pkg::K_END |-> packet_end && element_index == 15'd0)
        else $error("end or error record malformed");

endmodule

bind sensor_packet_tlv_parser spt_checker u_spt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .record_kind   (record_kind),
    .channel       (channel),
    .element_index (element_index),
    .value         (value),
    .packet_end    (packet_end)
);
